### rtl/duty_cycle_idle_injector_defines.svh
// ----------------------------------------------------------------------------
// Duty-cycle idle injector: assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DUTY_CYCLE_IDLE_INJECTOR_DEFINES_SVH
`define DUTY_CYCLE_IDLE_INJECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define DCII_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset
`define DCII_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DCII_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DCII_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/dcii_pkg.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector package
// Field widths, command and status codes, item and table entry types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcii_pkg;

   localparam int DEF_NUM_CPUS = 8;

   localparam int CMD_W    = 3;
   localparam int CPU_W    = 8;
   localparam int RATIO_W  = 7;
   localparam int MS_W     = 16;
   localparam int STATUS_W = 2;
   localparam int TICK_W   = 64;
   localparam int PROD_W   = MS_W + RATIO_W;

   // Commands
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_DUR    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   // Response status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

   localparam logic [RATIO_W-1:0] RATIO_FULL = 7'd100;

   // floor(p / 100) = (p * 10737419) >> 30, exact for p below 2^23
   localparam int DIV100_MUL_W = 24;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 24'd10737419;
   localparam int DIV100_SHIFT = 30;
   localparam int DIV100_Q_W   = 17;

   // floor(x / 10) = (x * 52429) >> 19, exact for 16-bit x
   localparam logic [MS_W-1:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SHIFT = 19;
   localparam int TICKS_W     = 13;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [CPU_W-1:0]   cpu;
      logic [RATIO_W-1:0] ratio;
      logic [MS_W-1:0]    duration_ms;
      logic [MS_W-1:0]    run_ms;
      logic [MS_W-1:0]    idle_ms;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                idle_now;
      logic                phase_switched;
   } rsp_item_type;

   // Per-CPU table entry; phase_start of zero means not yet stamped
   typedef struct packed {
      logic              in_idle;
      logic [MS_W-1:0]   run_len;
      logic [MS_W-1:0]   idle_len;
      logic [TICK_W-1:0] phase_start;
   } entry_type;

   // Request stage to core control
   typedef struct packed {
      logic             valid;
      logic             advance;
      logic             accept;
      logic [CPU_W-1:0] accept_cpu;
   } stage_ctl_type;

endpackage

### rtl/dcii_channels.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcii_req_if;
   logic                            valid;
   logic                            ready;
   logic [dcii_pkg::CMD_W-1:0]      cmd;
   logic [dcii_pkg::CPU_W-1:0]      cpu;
   logic [dcii_pkg::RATIO_W-1:0]    ratio;
   logic [dcii_pkg::MS_W-1:0]       duration_ms;
   logic [dcii_pkg::MS_W-1:0]       run_ms;
   logic [dcii_pkg::MS_W-1:0]       idle_ms;

   modport source (output valid, output cmd, output cpu, output ratio,
                   output duration_ms, output run_ms, output idle_ms, input ready);
   modport sink   (input valid, input cmd, input cpu, input ratio,
                   input duration_ms, input run_ms, input idle_ms, output ready);
endinterface

interface dcii_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dcii_pkg::STATUS_W-1:0]   status;
   logic                            idle_now;
   logic                            phase_switched;

   modport source (output valid, output status, output idle_now,
                   output phase_switched, input ready);
   modport sink   (input valid, input status, input idle_now,
                   input phase_switched, output ready);
endinterface

### rtl/dcii_req_stage.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector request stage
// Input register; also forms duration * ratio for the register command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcii_req_stage (
   input  logic                           clock,
   input  logic                           reset,
   dcii_req_if.sink                       req_ch,
   input  logic                           out_free,
   output dcii_pkg::stage_ctl_type        ctl,
   output dcii_pkg::req_item_type         item,
   output logic [dcii_pkg::PROD_W-1:0]    prod
);
   import dcii_pkg::*;

   logic                valid_ff;
   req_item_type        item_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                advance;
   logic                accept;

   // Stage moves on when the response register can take the result
   assign advance      = valid_ff && out_free;
   assign req_ch.ready = !valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload capture, product for the idle share
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd         <= req_ch.cmd;
         item_ff.cpu         <= req_ch.cpu;
         item_ff.ratio       <= req_ch.ratio;
         item_ff.duration_ms <= req_ch.duration_ms;
         item_ff.run_ms      <= req_ch.run_ms;
         item_ff.idle_ms     <= req_ch.idle_ms;
         prod_ff             <= PROD_W'(req_ch.duration_ms) * PROD_W'(req_ch.ratio);
      end
   end

   assign ctl.valid      = valid_ff;
   assign ctl.advance    = advance;
   assign ctl.accept     = accept;
   assign ctl.accept_cpu = req_ch.cpu;
   assign item           = item_ff;
   assign prod           = prod_ff;

endmodule

### rtl/dcii_core.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector core
// Per-CPU table, shared tick counter and the command logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcii_core #(
   parameter int NUM_CPUS = dcii_pkg::DEF_NUM_CPUS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dcii_pkg::stage_ctl_type        ctl,
   input  dcii_pkg::req_item_type         item,
   input  logic [dcii_pkg::PROD_W-1:0]    prod,
   output dcii_pkg::rsp_item_type         rsp_item
);
   import dcii_pkg::*;

   localparam int IDX_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CPU_LIM_W = CPU_W + 1;
   localparam logic [CPU_LIM_W-1:0] CPU_LIMIT = CPU_LIM_W'(NUM_CPUS);

   // Table memory, active flags and tick counter
   entry_type            table_mem [NUM_CPUS];
   entry_type            entry_ff;
   logic [NUM_CPUS-1:0]  active_ff;
   logic [TICK_W-1:0]    tick_ff;
   logic [TICK_W-1:0]    tick_in;

   logic                 cpu_ok;
   logic [IDX_W-1:0]     idx;
   logic [IDX_W-1:0]     rd_idx;
   logic                 act;
   logic                 act_new;
   logic                 act_wr;
   logic                 wr;
   logic                 wr_en;
   entry_type            entry_new;

   logic [PROD_W+DIV100_MUL_W-1:0] div100_full;
   logic [DIV100_Q_W-1:0]          idle_q;
   logic [MS_W-1:0]                reg_idle;
   logic [MS_W-1:0]                reg_run;
   logic [MS_W-1:0]                cur_len;
   logic [2*MS_W-1:0]              div10_full;
   logic [TICKS_W-1:0]             ticks;
   logic [TICK_W-1:0]              now;
   logic [TICK_W-1:0]              start;
   logic [TICK_W-1:0]              elapsed;
   logic                           toggle;
   logic [STATUS_W-1:0]            status;
   logic                           switched;

   assign idx    = item.cpu[IDX_W-1:0];
   assign rd_idx = ctl.accept_cpu[IDX_W-1:0];
   assign wr_en  = ctl.advance && wr;

   // Table read at acceptance, bypassing the write of the item ahead
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[idx] <= entry_new;
      end
      if (ctl.accept) begin
         if (wr_en && (idx == rd_idx)) begin
            entry_ff <= entry_new;
         end else begin
            entry_ff <= table_mem[rd_idx];
         end
      end
   end

   // Register split: idle = duration * ratio / 100, run = the rest, each at least 1 ms where the ratio allows
   always_comb begin
      div100_full = (PROD_W+DIV100_MUL_W)'(prod) * (PROD_W+DIV100_MUL_W)'(DIV100_MUL);
      idle_q      = div100_full[DIV100_SHIFT +: DIV100_Q_W];
      if (item.ratio == RATIO_FULL) begin
         reg_idle = item.duration_ms;
         reg_run  = '0;
      end else begin
         reg_idle = idle_q[MS_W-1:0];
         reg_run  = item.duration_ms - idle_q[MS_W-1:0];
      end
      if ((reg_run == '0) && (item.ratio < RATIO_FULL)) begin
         reg_run = MS_W'(1);
      end
      if ((reg_idle == '0) && (item.ratio != '0)) begin
         reg_idle = MS_W'(1);
      end
   end

   // Tick: phase length in ticks of 10 ms, at least one
   always_comb begin
      cur_len    = entry_ff.in_idle ? entry_ff.idle_len : entry_ff.run_len;
      div10_full = (2*MS_W)'(cur_len) * (2*MS_W)'(DIV10_MUL);
      ticks      = div10_full[DIV10_SHIFT +: TICKS_W];
      if (ticks == '0) begin
         ticks = TICKS_W'(1);
      end
      now     = tick_ff + TICK_W'(1);
      start   = (entry_ff.phase_start == '0) ? now : entry_ff.phase_start;
      elapsed = now - start;
      toggle  = elapsed >= TICK_W'(ticks);
   end

   // Command decode
   always_comb begin
      cpu_ok    = {1'b0, item.cpu} < CPU_LIMIT;
      act       = cpu_ok && active_ff[idx];
      act_new   = act;
      act_wr    = 1'b0;
      wr        = 1'b0;
      entry_new = entry_ff;
      tick_in   = tick_ff;
      status    = ST_INVALID;
      switched  = 1'b0;
      if (cpu_ok) begin
         case (item.cmd)
            CMD_REGISTER: begin
               if (item.ratio > RATIO_FULL) begin
                  status = ST_INVALID;
               end else if (act) begin
                  status = ST_BUSY;
               end else begin
                  status                = ST_OK;
                  act_new               = 1'b1;
                  act_wr                = 1'b1;
                  wr                    = 1'b1;
                  entry_new.in_idle     = 1'b0;
                  entry_new.phase_start = '0;
                  entry_new.run_len     = reg_run;
                  entry_new.idle_len    = reg_idle;
               end
            end
            CMD_UNREGISTER: begin
               if (act) begin
                  status             = ST_OK;
                  act_new            = 1'b0;
                  act_wr             = 1'b1;
                  wr                 = 1'b1;
                  entry_new.in_idle  = 1'b0;
                  entry_new.run_len  = '0;
                  entry_new.idle_len = '0;
               end
            end
            CMD_SET_DUR: begin
               if (act) begin
                  status                = ST_OK;
                  wr                    = 1'b1;
                  entry_new.in_idle     = 1'b0;
                  entry_new.phase_start = '0;
                  entry_new.run_len     = item.run_ms;
                  entry_new.idle_len    = item.idle_ms;
               end
            end
            CMD_TICK: begin
               if (act) begin
                  status   = ST_OK;
                  wr       = 1'b1;
                  tick_in  = now;
                  switched = toggle;
                  if (toggle) begin
                     entry_new.in_idle     = !entry_ff.in_idle;
                     entry_new.phase_start = now;
                  end else begin
                     entry_new.phase_start = start;
                  end
               end
            end
            CMD_QUERY: begin
               if (act) begin
                  status = ST_OK;
               end
            end
            default: begin
               status = ST_INVALID;
            end
         endcase
      end
      rsp_item.status         = status;
      rsp_item.idle_now       = cpu_ok && act_new && entry_new.in_idle;
      rsp_item.phase_switched = switched;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         tick_ff   <= '0;
      end else if (ctl.advance) begin
         if (act_wr) begin
            active_ff[idx] <= act_new;
         end
         tick_ff <= tick_in;
      end
   end

endmodule

### rtl/dcii_rsp_reg.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector response register
// Holds one result until the response channel takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcii_rsp_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  dcii_pkg::rsp_item_type  rsp_item,
   output logic                    out_free,
   dcii_rsp_if.source              rsp_ch
);
   import dcii_pkg::*;

   logic          valid_ff;
   rsp_item_type  item_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= rsp_item;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.status         = item_ff.status;
   assign rsp_ch.idle_now       = item_ff.idle_now;
   assign rsp_ch.phase_switched = item_ff.phase_switched;

endmodule

### rtl/duty_cycle_idle_injector.sv
// ----------------------------------------------------------------------------
// Duty-cycle idle injector
// Per-CPU run/idle phase table driven by register, unregister, set, tick and
// query requests; one response for every request.
//
//   channel   dir   handshake       payload
//   req_ch    in    valid / ready   cmd, cpu, ratio, duration_ms, run_ms, idle_ms
//   rsp_ch    out   valid / ready   status, idle_now, phase_switched
//
// One request per cycle sustained while rsp_ch takes responses; a request passes
// through the input register, then the response register, before its response is valid.
// The table is read when a request is taken and written when it leaves the
// input register, so back-to-back requests to one CPU see each other.
// Synchronous reset clears the active flags and the tick counter; no sweep.
// A stalled response holds the input register, which then holds req_ch.ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "duty_cycle_idle_injector_defines.svh"

module duty_cycle_idle_injector #(
   parameter int NUM_CPUS = dcii_pkg::DEF_NUM_CPUS
) (
   input  logic          clock,
   input  logic          reset,
   dcii_req_if.sink      req_ch,
   dcii_rsp_if.source    rsp_ch
);
   import dcii_pkg::*;

   stage_ctl_type       ctl;
   req_item_type        item;
   logic [PROD_W-1:0]   prod;
   rsp_item_type        rsp_item;
   logic                out_free;

   // Input register
   dcii_req_stage u_req_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .ctl      (ctl),
      .item     (item),
      .prod     (prod)
   );

   // Table and command logic
   dcii_core #(
      .NUM_CPUS (NUM_CPUS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .item     (item),
      .prod     (prod),
      .rsp_item (rsp_item)
   );

   // Response register
   dcii_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (ctl.advance),
      .rsp_item (rsp_item),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   // Checks
   `DCII_ASSERT_NEXT(a_stall_holds, clock, reset, ctl.valid && !out_free, ctl.valid, "stalled request dropped")
   `DCII_ASSERT_NEXT(a_advance_rsp, clock, reset, ctl.advance, rsp_ch.valid, "advanced request gave no response")
   `DCII_ASSERT_SAME(a_switch_ok, clock, reset, rsp_ch.valid && rsp_ch.phase_switched, rsp_ch.status == ST_OK, "phase switch on failed request")

endmodule

### tb/duty_cycle_idle_injector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duty-cycle idle injector testbench
// Drives register, unregister, set, tick and query requests through the
// request channel and checks every response against a local model of the
// per-CPU run/idle table or, for typed directed rows, a fixed expectation. A short
// directed list comes first, then random traffic with gaps on both channels, a long
// response stall and a drain pause, and a back-to-back stretch.

module duty_cycle_idle_injector_test;
   import dcii_pkg::*;

   localparam int NUM_CPUS = DEF_NUM_CPUS;
   localparam int LAST_CPU = 2**CPU_W - 1;
   localparam logic [CMD_W-1:0]   CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]   CMD_RSVD_LAST  = 3'd7;
   localparam logic [RATIO_W-1:0] RATIO_MAX      = '1;
   localparam logic [MS_W-1:0]    MS_MAX         = '1;
   localparam int PERCENT      = 100;
   localparam int MS_PER_TICK  = 10;
   localparam int HOLD_CYCLES  = 200;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   dcii_req_if req_ch ();
   dcii_rsp_if rsp_ch ();

   duty_cycle_idle_injector #(
      .NUM_CPUS (NUM_CPUS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Local copy of the CPU table
   logic              cpu_active      [NUM_CPUS];
   logic              cpu_idle_phase  [NUM_CPUS];
   logic [MS_W-1:0]   cpu_run_len     [NUM_CPUS];
   logic [MS_W-1:0]   cpu_idle_len    [NUM_CPUS];
   logic [TICK_W-1:0] cpu_phase_start [NUM_CPUS];
   logic [TICK_W-1:0] shared_ticks;

   rsp_item_type pending_rsp [$];
   int           mismatch_count  = 0;
   int           rsp_hold_cycles = 0;
   bit           steady_flow     = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Millisecond field: small values keep phases short enough to toggle
   function automatic logic [MS_W-1:0] random_ms();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return MS_W'($urandom_range(0, 200));
      if (pick < 88) return MS_W'($urandom_range(0, 3000));
      if (pick < 94) return pick[0] ? MS_MAX : '0;
      return MS_W'($urandom_range(0, MS_MAX));
   endfunction

   // Apply one request to the local table and return its response
   function automatic rsp_item_type apply_command(req_item_type r);
      rsp_item_type      result;
      int unsigned       c;
      int unsigned       idle_calc;
      int unsigned       run_calc;
      int unsigned       span;
      logic [MS_W-1:0]   len;
      logic [TICK_W-1:0] elapsed;
      result.status         = ST_INVALID;
      result.idle_now       = 1'b0;
      result.phase_switched = 1'b0;
      if (32'(r.cpu) >= NUM_CPUS) return result;
      c = 32'(r.cpu);
      case (r.cmd)
         CMD_REGISTER: begin
            if (r.ratio > RATIO_FULL) begin
               result.status = ST_INVALID;
            end else if (cpu_active[c]) begin
               result.status = ST_BUSY;
            end else begin
               if (r.ratio == RATIO_FULL) begin
                  run_calc  = 0;
                  idle_calc = 32'(r.duration_ms);
               end else begin
                  idle_calc = 32'(r.duration_ms);
                  idle_calc = idle_calc * 32'(r.ratio) / PERCENT;
                  run_calc  = 32'(r.duration_ms) - idle_calc;
               end
               // 1 ms floor on each phase that the ratio allows
               if (run_calc == 0 && r.ratio < RATIO_FULL) run_calc = 1;
               if (idle_calc == 0 && r.ratio != 0) idle_calc = 1;
               cpu_active[c]      = 1'b1;
               cpu_idle_phase[c]  = 1'b0;
               cpu_phase_start[c] = '0;
               cpu_run_len[c]     = run_calc[MS_W-1:0];
               cpu_idle_len[c]    = idle_calc[MS_W-1:0];
               result.status      = ST_OK;
            end
         end
         CMD_UNREGISTER: begin
            if (cpu_active[c]) begin
               cpu_active[c]     = 1'b0;
               cpu_run_len[c]    = '0;
               cpu_idle_len[c]   = '0;
               cpu_idle_phase[c] = 1'b0;
               result.status     = ST_OK;
            end
         end
         CMD_SET_DUR: begin
            if (cpu_active[c]) begin
               cpu_run_len[c]     = r.run_ms;
               cpu_idle_len[c]    = r.idle_ms;
               cpu_idle_phase[c]  = 1'b0;
               cpu_phase_start[c] = '0;
               result.status      = ST_OK;
            end
         end
         CMD_TICK: begin
            if (cpu_active[c]) begin
               shared_ticks = shared_ticks + TICK_W'(1);
               // a zero start stamp means unset; the first tick stamps it
               if (cpu_phase_start[c] == '0) cpu_phase_start[c] = shared_ticks;
               elapsed = shared_ticks - cpu_phase_start[c];
               len  = cpu_idle_phase[c] ? cpu_idle_len[c] : cpu_run_len[c];
               span = 32'(len) / MS_PER_TICK;
               if (span < 1) span = 1;
               if (elapsed >= TICK_W'(span)) begin
                  cpu_idle_phase[c]     = ~cpu_idle_phase[c];
                  cpu_phase_start[c]    = shared_ticks;
                  result.phase_switched = 1'b1;
               end
               result.status = ST_OK;
            end
         end
         CMD_QUERY: begin
            if (cpu_active[c]) result.status = ST_OK;
         end
         default: result.status = ST_INVALID;
      endcase
      result.idle_now = cpu_active[c] & cpu_idle_phase[c];
      return result;
   endfunction

   function automatic directed_row_type make_row(logic [CMD_W-1:0] cmd, int cpu, int ratio,
                                                 int dur, int run, int idle, bit typed,
                                                 logic [STATUS_W-1:0] status, bit idle_now);
      directed_row_type row;
      row.req.cmd            = cmd;
      row.req.cpu            = CPU_W'(cpu);
      row.req.ratio          = RATIO_W'(ratio);
      row.req.duration_ms    = MS_W'(dur);
      row.req.run_ms         = MS_W'(run);
      row.req.idle_ms        = MS_W'(idle);
      row.typed              = typed;
      row.rsp.status         = status;
      row.rsp.idle_now       = idle_now;
      row.rsp.phase_switched = 1'b0;
      return row;
   endfunction

   // Offer one request, wait for it to be taken, then record its expected response
   task automatic send_request(req_item_type r, bit typed, rsp_item_type typed_rsp);
      rsp_item_type predicted;
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= r.cmd;
      req_ch.cpu         <= r.cpu;
      req_ch.ratio       <= r.ratio;
      req_ch.duration_ms <= r.duration_ms;
      req_ch.run_ms      <= r.run_ms;
      req_ch.idle_ms     <= r.idle_ms;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_command(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // Random requests, weighted toward ticks on valid CPUs
   task automatic send_random(int count, bit with_gaps);
      req_item_type r;
      int           pick;
      int           gap;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)      r.cmd = CMD_REGISTER;
         else if (pick < 17) r.cmd = CMD_UNREGISTER;
         else if (pick < 25) r.cmd = CMD_SET_DUR;
         else if (pick < 82) r.cmd = CMD_TICK;
         else if (pick < 94) r.cmd = CMD_QUERY;
         else                r.cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));

         pick = $urandom_range(0, 99);
         if (pick < 85)      r.cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
         else if (pick < 95) r.cpu = CPU_W'($urandom_range(NUM_CPUS, LAST_CPU));
         else                r.cpu = CPU_W'(LAST_CPU);

         pick = $urandom_range(0, 99);
         if (pick < 10)      r.ratio = '0;
         else if (pick < 22) r.ratio = RATIO_FULL;
         else if (pick < 88) r.ratio = RATIO_W'($urandom_range(1, RATIO_FULL - 1));
         else                r.ratio = RATIO_W'($urandom_range(RATIO_FULL + 1, RATIO_MAX));

         r.duration_ms = random_ms();
         r.run_ms      = random_ms();
         r.idle_ms     = random_ms();

         send_request(r, 1'b0, '0);
         gap = with_gaps ? pick_gap() : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Response ready: random stalls, long hold on request, or always ready
   initial begin : rsp_ready_gen
      int stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            stall = steady_flow ? 0 : pick_gap();
            if (stall == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // Response checker
   initial begin : rsp_checker
      rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response: status=%0d idle_now=%0b switched=%0b",
                           rsp_ch.status, rsp_ch.idle_now, rsp_ch.phase_switched);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.idle_now !== want.idle_now ||
                   rsp_ch.phase_switched !== want.phase_switched) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("response mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              want.status, want.idle_now, want.phase_switched,
                              rsp_ch.status, rsp_ch.idle_now, rsp_ch.phase_switched);
               end
            end
         end
      end
   end

   // Main sequence
   initial begin : main_seq
      directed_row_type rows [$];
      int               drain;
      int               gap;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= '0;
      req_ch.cpu         <= '0;
      req_ch.ratio       <= '0;
      req_ch.duration_ms <= '0;
      req_ch.run_ms      <= '0;
      req_ch.idle_ms     <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
         cpu_active[i]      = 1'b0;
         cpu_idle_phase[i]  = 1'b0;
         cpu_run_len[i]     = '0;
         cpu_idle_len[i]    = '0;
         cpu_phase_start[i] = '0;
      end
      shared_ticks = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, range checks, floors, busy, first toggles
      rows.push_back(make_row(CMD_QUERY,      0, 0, 0, 0, 0, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_TICK,       0, 0, 0, 0, 0, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_REGISTER, NUM_CPUS, 50, 100, 0, 0, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_REGISTER,   0, RATIO_FULL + 1, 100, 0, 0, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_REGISTER,   0, RATIO_MAX, MS_MAX, MS_MAX, MS_MAX, 1,
                              ST_INVALID, 0));
      rows.push_back(make_row(CMD_REGISTER,   0, RATIO_FULL, 0, 0, 0, 1, ST_OK, 0));
      rows.push_back(make_row(CMD_REGISTER,   0, 0, 5, 0, 0, 1, ST_BUSY, 0));
      rows.push_back(make_row(CMD_TICK,       0, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_TICK,       0, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_TICK,       0, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_REGISTER, NUM_CPUS - 1, 0, 0, 0, 0, 1, ST_OK, 0));
      rows.push_back(make_row(CMD_REGISTER,   1, 50, MS_MAX, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_REGISTER,   2, RATIO_FULL, MS_MAX, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_REGISTER,   3, 1, 99, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_TICK, NUM_CPUS - 1, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_TICK, NUM_CPUS - 1, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_SET_DUR,    0, 0, 0, 0, MS_MAX, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_SET_DUR,    4, 0, 0, MS_MAX, MS_MAX, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_SET_DUR, NUM_CPUS - 1, 0, 0, MS_MAX, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_RSVD_FIRST, 0, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_RSVD_LAST, LAST_CPU, RATIO_MAX, MS_MAX, MS_MAX, MS_MAX, 1,
                              ST_INVALID, 0));
      rows.push_back(make_row(CMD_UNREGISTER, 0, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_UNREGISTER, 0, 0, 0, 0, 0, 1, ST_INVALID, 0));
      rows.push_back(make_row(CMD_QUERY,      1, 0, 0, 0, 0, 0, ST_OK, 0));
      rows.push_back(make_row(CMD_QUERY, LAST_CPU, 0, 0, 0, 0, 1, ST_INVALID, 0));

      foreach (rows[i]) begin
         send_request(rows[i].req, rows[i].typed, rows[i].rsp);
         gap = pick_gap();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // Random traffic with gaps on both sides
      send_random(350, 1'b1);

      // Long response stall while requests keep coming, then drain
      rsp_hold_cycles = HOLD_CYCLES;
      send_random(40, 1'b0);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);

      // Back-to-back stretch with no idling on either side
      steady_flow = 1'b1;
      send_random(200, 1'b0);
      steady_flow = 1'b0;

      send_random(400, 1'b1);

      // Wait for outstanding responses, then report any that never arrived
      req_ch.valid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (pending_rsp.size() != 0 && drain < 20000);
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         mismatch_count += pending_rsp.size();
         $display("%0d responses never arrived", pending_rsp.size());
      end

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### duty_cycle_idle_injector.f
+incdir+rtl
rtl/dcii_pkg.sv
rtl/dcii_channels.sv
rtl/dcii_req_stage.sv
rtl/dcii_core.sv
rtl/dcii_rsp_reg.sv
rtl/duty_cycle_idle_injector.sv
tb/duty_cycle_idle_injector_test.sv
